// ===== hdl/atm_pkg.sv =====
// shared types, constants and register indexes for the alpha-trimmed mean filter
package atm_pkg;

  localparam int DEF_MAX_RADIUS = 3;
  localparam int DEF_MAX_WIDTH  = 1024;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_PERCENT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd2;

  localparam logic [1:0]  RST_KERNEL_RADIUS = 2'd1;
  localparam logic [6:0]  RST_TRIM_PERCENT  = 7'd0;
  localparam logic [10:0] RST_IMAGE_WIDTH   = 11'd640;

  localparam logic [6:0] PCT_MAX = 7'd100;

  // x / 100 as (x * RECIP_100) >> RECIP_SHIFT, exact for x below 43690
  localparam int RECIP_100   = 20972;
  localparam int RECIP_SHIFT = 21;

  localparam int PIX_W = 24;

  typedef struct packed {
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
    logic       frame_end;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       last_out;
  } pix_out_t;

  typedef struct packed {
    logic load;
    logic start;
    logic ack;
  } lane_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_START,
    S_WAIT
  } top_state_t;

  typedef enum logic [1:0] {
    L_IDLE,
    L_RANK,
    L_DIV,
    L_DONE
  } lane_state_t;

endpackage

// ===== hdl/atm_line_mem.sv =====
// line store memory: one write port, one registered read port
module atm_line_mem import atm_pkg::*; #(
  parameter int DEPTH = 7 * DEF_MAX_WIDTH,
  parameter int AW    = $clog2(7 * DEF_MAX_WIDTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [PIX_W-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [PIX_W-1:0] rdata
);

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/atm_lane.sv =====
// one colour lane: window registers, rank scan with central sum, rounding divider
module atm_lane import atm_pkg::*; #(
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic       clk,
  input  logic       rst,
  input  lane_ctrl_t ctrl,
  input  logic [$clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1))-1:0] load_idx,
  input  logic [7:0] load_val,
  input  logic [$clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)+1)-1:0] win_size,
  input  logic [$clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)+1)-1:0] rank_lo,
  input  logic [$clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)+1)-1:0] rank_hi,
  input  logic [$clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)+1)-1:0] divisor,
  output logic       done,
  output logic [7:0] result
);

  localparam int SIDE = 2 * MAX_RADIUS + 1;
  localparam int WMAX = SIDE * SIDE;
  localparam int KW   = $clog2(WMAX);
  localparam int WBW  = $clog2(WMAX + 1);
  localparam int SW   = $clog2(WMAX * 255 + 1);
  localparam int CNTW = $clog2(SW + 1);

  lane_state_t state, state_next;

  logic [7:0]    win [WMAX];
  logic [KW-1:0] idx;
  logic [SW-1:0] sum;
  logic [SW-1:0] quo;
  logic [WBW-1:0] rem;
  logic [CNTW-1:0] steps;

  logic [7:0]     cur;
  logic [WMAX-1:0] lt;
  logic [WBW-1:0] rank;
  logic [SW-1:0]  sum_next;
  logic           last_elem;
  logic [WBW:0]   trial;
  logic [WBW:0]   diff;
  logic           ge;
  logic [WBW:0]   rem2;
  logic           round_up;
  logic [SW:0]    q_round;

  // rank of the current element, ties broken by position
  always_comb begin
    cur = win[idx];
    for (int j = 0; j < WMAX; j++) begin
      lt[j] = (j < int'(win_size)) &&
              ((win[j] < cur) || ((win[j] == cur) && (j < int'(idx))));
    end
    rank      = WBW'($countones(lt));
    sum_next  = sum + (((rank >= rank_lo) && (rank <= rank_hi)) ? SW'(cur) : '0);
    last_elem = (int'(idx) == int'(win_size) - 1);
  end

  // restoring divider step
  always_comb begin
    trial = {rem, quo[SW-1]};
    ge    = trial >= {1'b0, divisor};
    diff  = trial - {1'b0, divisor};
  end

  // round to nearest, ties to even
  always_comb begin
    rem2     = {rem, 1'b0};
    round_up = (rem2 > {1'b0, divisor}) || ((rem2 == {1'b0, divisor}) && quo[0]);
    q_round  = {1'b0, quo} + (SW+1)'(round_up);
    result   = (q_round > (SW+1)'(255)) ? 8'hFF : q_round[7:0];
    done     = (state == L_DONE);
  end

  always_comb begin
    state_next = state;
    case (state)
      L_IDLE: begin
        if (ctrl.start) state_next = L_RANK;
      end
      L_RANK: begin
        if (last_elem) state_next = L_DIV;
      end
      L_DIV: begin
        if (int'(steps) == SW - 1) state_next = L_DONE;
      end
      L_DONE: begin
        if (ctrl.ack) state_next = L_IDLE;
      end
      default: state_next = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      win[load_idx] <= load_val;
    end
    case (state)
      L_IDLE: begin
        idx <= '0;
        sum <= '0;
      end
      L_RANK: begin
        sum <= sum_next;
        idx <= idx + 1'b1;
        if (last_elem) begin
          quo   <= sum_next;
          rem   <= '0;
          steps <= '0;
        end
      end
      L_DIV: begin
        rem   <= ge ? diff[WBW-1:0] : trial[WBW-1:0];
        quo   <= {quo[SW-2:0], ge};
        steps <= steps + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/alpha_trimmed_mean_filter.sv =====
// top level of the alpha-trimmed mean filter: control, line store and lane merge
//
// pixels come in on in_valid/in_stall with payload in_data, one item per pixel in
// raster order; filtered pixels leave on out_valid/out_stall with payload out_data
// an item is taken at a clock edge with valid high and stall low on that channel
// registers are written on cfg_valid/cfg_ready (cfg_ready is always high), index
// cfg_index and data cfg_data: 0 kernel radius, 1 trim percent, 2 image width
// a pixel whose window is not complete gives no item and leaves the block ready for the next
// a pixel completing a window goes through S_READ, which reads its window from
// the line store one pixel a cycle, S_START, which starts the three colour lanes,
// and S_WAIT, which writes their result to the output register once they finish
// and it is free; no pixel is taken until S_IDLE; the window holds W = (2r+1)^2
// pixels and its sum is 14 bits wide with MAX_RADIUS 3; each lane scans its W
// values once to rank them and runs a one-bit-a-cycle divider on that sum;
// while out_stall holds the output register a finished window waits in the lanes
// and no further pixel is taken; the block never drops a finished item
// rst (synchronous) clears counters, registers to their reset values and the
// handshake state; the line store holds no reset and needs no clearing pass
module alpha_trimmed_mean_filter import atm_pkg::*; #(
  parameter int MAX_RADIUS = DEF_MAX_RADIUS,
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pix_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pix_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ROWS = 2 * MAX_RADIUS + 1;
  localparam int WMAX = ROWS * ROWS;
  localparam int KW   = $clog2(WMAX);
  localparam int WBW  = $clog2(WMAX + 1);
  localparam int RW   = $clog2(MAX_RADIUS + 1);
  localparam int DW   = RW + 1;                    // window offsets up to 2r
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int EW   = (CW + 1 > 11) ? CW + 1 : 11;
  localparam int SLW  = $clog2(ROWS);
  localparam int DEPTH = ROWS * MAX_WIDTH;
  localparam int AW   = $clog2(DEPTH);
  localparam int PW   = WBW + 7;
  localparam int MW   = PW + 15;

  // configuration registers
  logic [1:0]  kernel_radius;
  logic [6:0]  trim_percent;
  logic [10:0] image_width;

  // frame position
  logic [CW-1:0]  column_count;
  logic [15:0]    row_count;
  logic [SLW-1:0] row_slot;

  // item in flight
  top_state_t state, state_next;
  logic [CW-1:0]  col;
  logic           frame_last;
  logic [DW-1:0]  dr, dc;
  logic [SLW-1:0] rd_slot;
  logic [KW-1:0]  k;
  logic           ld;
  logic [KW-1:0]  ld_idx;

  // trim settings pipeline
  logic [PW-1:0]  prod;
  logic [WBW-1:0] rank_lo, rank_hi, divisor;

  logic     out_valid_next;
  pix_out_t out_data_next;

  // combinational helpers
  logic [RW-1:0]  rad;
  logic [DW-1:0]  span;            // 2r, also side - 1
  logic [WBW-1:0] win_size;
  logic [6:0]     pct;
  logic [EW-1:0]  eff;
  logic [CW-1:0]  col_c;
  logic           win_ok;
  logic           accept;
  logic           row_end;
  logic [MW-1:0]  scaled;
  logic [WBW-1:0] trim_n;
  logic [WBW-1:0] mid;
  logic [AW-1:0]  waddr, raddr;
  logic [PIX_W-1:0] rdata;
  lane_ctrl_t     lane_ctrl;
  logic [2:0]     lane_done;
  logic [7:0]     res_b, res_g, res_r;
  logic           out_free;

  assign cfg_ready = 1'b1;

  // effective settings
  always_comb begin
    if (int'(kernel_radius) > MAX_RADIUS) begin
      rad = RW'(MAX_RADIUS);
    end else begin
      rad = RW'(kernel_radius);
    end
    span     = {rad, 1'b0};
    win_size = WBW'((int'(span) + 1) * (int'(span) + 1));
    pct      = (trim_percent > PCT_MAX) ? PCT_MAX : trim_percent;
    if (image_width == '0) begin
      eff = EW'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      eff = EW'(MAX_WIDTH);
    end else begin
      eff = EW'(image_width);
    end
    // a column beyond a shrunk width counts as the row's last pixel
    if (EW'(column_count) >= eff) begin
      col_c = CW'(eff - 1'b1);
    end else begin
      col_c = column_count;
    end
    win_ok  = (row_count >= 16'(span)) && (col_c >= CW'(span));
    row_end = (EW'(col_c) + 1'b1) >= eff;
    waddr   = AW'(row_slot) * AW'(MAX_WIDTH) + AW'(col_c);
    raddr   = AW'(rd_slot) * AW'(MAX_WIDTH) + AW'(col - CW'(dc));
  end

  // n = floor(floor(W * pct / 100) / 2), then rank bounds around the median
  always_comb begin
    scaled = MW'(prod) * MW'(RECIP_100);
    trim_n = WBW'(scaled >> (RECIP_SHIFT + 1));
    mid    = win_size >> 1;
  end

  assign out_free = !out_valid || !out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next      = state;
    in_stall        = 1'b1;
    lane_ctrl.load  = ld;
    lane_ctrl.start = 1'b0;
    lane_ctrl.ack   = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && win_ok) state_next = S_READ;
      end
      S_READ: begin
        if ((dc == span) && (dr == span)) state_next = S_START;
      end
      S_START: begin
        lane_ctrl.start = 1'b1;
        state_next      = S_WAIT;
      end
      S_WAIT: begin
        if ((&lane_done) && out_free) begin
          lane_ctrl.ack = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_next = out_valid && out_stall;
    out_data_next  = out_data;
    if (lane_ctrl.ack) begin
      out_valid_next          = 1'b1;
      out_data_next.blue_out  = res_b;
      out_data_next.green_out = res_g;
      out_data_next.red_out   = res_r;
      out_data_next.last_out  = frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      kernel_radius <= RST_KERNEL_RADIUS;
      trim_percent  <= RST_TRIM_PERCENT;
      image_width   <= RST_IMAGE_WIDTH;
      column_count  <= '0;
      row_count     <= '0;
      row_slot      <= '0;
      ld            <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      ld        <= (state == S_READ);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KERNEL_RADIUS: kernel_radius <= cfg_data[1:0];
          REG_TRIM_PERCENT:  trim_percent  <= cfg_data[6:0];
          REG_IMAGE_WIDTH:   image_width   <= cfg_data;
          default: begin
          end
        endcase
      end
      if (accept) begin
        if (in_data.frame_end) begin
          column_count <= '0;
          row_count    <= '0;
          row_slot     <= '0;
        end else if (row_end) begin
          column_count <= '0;
          if (row_count != 16'hFFFF) row_count <= row_count + 1'b1;
          row_slot <= (int'(row_slot) == ROWS - 1) ? '0 : row_slot + 1'b1;
        end else begin
          column_count <= col_c + 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod     <= PW'(win_size) * PW'(pct);
    rank_lo  <= mid - trim_n;
    rank_hi  <= mid + trim_n;
    divisor  <= {trim_n[WBW-2:0], 1'b1};
    out_data <= out_data_next;
    ld_idx   <= k;
    if (accept) begin
      col        <= col_c;
      frame_last <= in_data.frame_end;
      rd_slot    <= row_slot;
      dr         <= '0;
      dc         <= '0;
      k          <= '0;
    end else if (state == S_READ) begin
      k <= k + 1'b1;
      if (dc == span) begin
        dc      <= '0;
        dr      <= dr + 1'b1;
        rd_slot <= (rd_slot == '0) ? SLW'(ROWS - 1) : rd_slot - 1'b1;
      end else begin
        dc <= dc + 1'b1;
      end
    end
  end

  atm_line_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_line_mem (
    .clk   (clk),
    .we    (accept),
    .waddr (waddr),
    .wdata ({in_data.red_in, in_data.green_in, in_data.blue_in}),
    .raddr (raddr),
    .rdata (rdata)
  );

  atm_lane #(.MAX_RADIUS(MAX_RADIUS)) u_lane_b (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (lane_ctrl),
    .load_idx (ld_idx),
    .load_val (rdata[7:0]),
    .win_size (win_size),
    .rank_lo  (rank_lo),
    .rank_hi  (rank_hi),
    .divisor  (divisor),
    .done     (lane_done[0]),
    .result   (res_b)
  );

  atm_lane #(.MAX_RADIUS(MAX_RADIUS)) u_lane_g (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (lane_ctrl),
    .load_idx (ld_idx),
    .load_val (rdata[15:8]),
    .win_size (win_size),
    .rank_lo  (rank_lo),
    .rank_hi  (rank_hi),
    .divisor  (divisor),
    .done     (lane_done[1]),
    .result   (res_g)
  );

  atm_lane #(.MAX_RADIUS(MAX_RADIUS)) u_lane_r (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (lane_ctrl),
    .load_idx (ld_idx),
    .load_val (rdata[23:16]),
    .win_size (win_size),
    .rank_lo  (rank_lo),
    .rank_hi  (rank_hi),
    .divisor  (divisor),
    .done     (lane_done[2]),
    .result   (res_r)
  );

endmodule

// ===== dv/alpha_trimmed_mean_filter_tb.sv =====
// testbench for the alpha-trimmed mean filter: directed and random frames checked against a built-in predictor
`timescale 1ns / 100ps

module alpha_trimmed_mean_filter_tb;
  import atm_pkg::*;

  localparam int ROWS_KEPT = 2 * DEF_MAX_RADIUS + 1;
  localparam int WIN_MAX   = ROWS_KEPT * ROWS_KEPT;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_stall;
  pix_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  pix_out_t out_data;
  logic     cfg_valid;
  logic     cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  alpha_trimmed_mean_filter i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // pixels waiting to be offered, and filtered pixels still owed by the block
  pix_in_t  pending_pixels[$];
  pix_out_t owed_pixels[$];

  // predictor state: its own copy of the line store, position and registers
  logic [23:0] row_mem [0:ROWS_KEPT*DEF_MAX_WIDTH-1];
  int unsigned col_pos, rows_done, cur_slot;
  logic [1:0]  radius_reg;
  logic [6:0]  percent_reg;
  logic [10:0] width_reg;

  int  fails, pixels_in, pixels_out, windows_seen, sent_count, phase_count;
  bit  quiet;       // no idling in the last part of the run
  bit  hold_go, hold_done;
  int  hold_left, stall_burst, send_gap;

  // rank the window values and average the 2n+1 around the median, rounding
  // to nearest with ties to even
  function automatic logic [7:0] trimmed_avg(input int vals[WIN_MAX], input int w,
                                             input int n);
    int v[WIN_MAX];
    int i, j, x, sum, d, q, rem, mid;
    v = vals;
    for (i = 1; i < w; i++) begin
      x = v[i];
      j = i;
      while (j > 0 && v[j-1] > x) begin
        v[j] = v[j-1];
        j--;
      end
      v[j] = x;
    end
    mid = w / 2;
    sum = 0;
    for (i = mid - n; i <= mid + n; i++) sum += v[i];
    d = 2 * n + 1;
    q = sum / d;
    rem = sum % d;
    if (2 * rem > d || (2 * rem == d && q[0])) q++;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  // advance the predictor by one pixel; returns 1 when a filtered pixel is due
  function automatic bit filter_pixel(input pix_in_t px, output pix_out_t res);
    int vb[WIN_MAX], vg[WIN_MAX], vr[WIN_MAX];
    int unsigned eff, rad, pct, col, side, w, n, dr, dc, k, slot;
    logic [23:0] p;
    bit got;
    eff = width_reg;
    if (eff < 1) eff = 1;
    if (eff > DEF_MAX_WIDTH) eff = DEF_MAX_WIDTH;
    rad = radius_reg > DEF_MAX_RADIUS ? DEF_MAX_RADIUS : radius_reg;
    pct = percent_reg > PCT_MAX ? PCT_MAX : percent_reg;
    col = col_pos;
    // width shrunk mid-row: pixel closes its row
    if (col >= eff) col = eff - 1;
    row_mem[cur_slot*DEF_MAX_WIDTH + col] = {px.red_in, px.green_in, px.blue_in};
    side = 2 * rad + 1;
    got = 0;
    res = '0;
    if (rows_done >= 2 * rad && col >= 2 * rad) begin
      w = side * side;
      n = (w * pct / 100) / 2;
      k = 0;
      for (dr = 0; dr < side; dr++) begin
        slot = (cur_slot + ROWS_KEPT - dr) % ROWS_KEPT;
        for (dc = 0; dc < side; dc++) begin
          p = row_mem[slot*DEF_MAX_WIDTH + col - dc];
          vb[k] = p[7:0];
          vg[k] = p[15:8];
          vr[k] = p[23:16];
          k++;
        end
      end
      res.blue_out  = trimmed_avg(vb, w, n);
      res.green_out = trimmed_avg(vg, w, n);
      res.red_out   = trimmed_avg(vr, w, n);
      res.last_out  = px.frame_end;
      got = 1;
    end
    if (px.frame_end) begin
      col_pos = 0;
      rows_done = 0;
      cur_slot = 0;
    end else if (col + 1 >= eff) begin
      col_pos = 0;
      if (rows_done < 65535) rows_done++;
      cur_slot = (cur_slot + 1) % ROWS_KEPT;
    end else begin
      col_pos = col + 1;
    end
    return got;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver: offers queued pixels, with random gaps, and feeds the predictor
  // on every accepted item
  always @(posedge clk) begin
    pix_out_t r;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        pixels_in++;
        if (filter_pixel(in_data, r)) begin
          owed_pixels = {owed_pixels, r};
          windows_seen++;
        end
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          in_data  <= pending_pixels.pop_front();
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 11) == 0) send_gap = $urandom_range(1, 12);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall: random bursts, plus one long hold-off so the block backs up
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
      stall_burst = 0;
    end else begin
      if (hold_go && !hold_done) begin
        hold_left = 600;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_burst > 0) begin
        stall_burst--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_burst = $urandom_range(0, 11);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor: each filtered pixel against the oldest one owed
  always @(posedge clk) begin
    pix_out_t e;
    if (!rst && out_valid && !out_stall) begin
      pixels_out++;
      if (owed_pixels.size() == 0) begin
        $error("filtered pixel with none expected: %h", out_data);
        fails++;
      end else begin
        e = owed_pixels.pop_front();
        if (out_data.blue_out !== e.blue_out) begin
          $error("blue_out: expected %0d, got %0d", e.blue_out, out_data.blue_out);
          fails++;
        end
        if (out_data.green_out !== e.green_out) begin
          $error("green_out: expected %0d, got %0d", e.green_out, out_data.green_out);
          fails++;
        end
        if (out_data.red_out !== e.red_out) begin
          $error("red_out: expected %0d, got %0d", e.red_out, out_data.red_out);
          fails++;
        end
        if (out_data.last_out !== e.last_out) begin
          $error("last_out: expected %0d, got %0d", e.last_out, out_data.last_out);
          fails++;
        end
      end
    end
  end

  // register write, called just after a rising edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_KERNEL_RADIUS: radius_reg  = val[1:0];
      REG_TRIM_PERCENT:  percent_reg = val[6:0];
      REG_IMAGE_WIDTH:   width_reg   = val[10:0];
      default: ;
    endcase
  endtask

  // wait until every pixel is taken and every filtered pixel has come back
  task automatic drain;
    while (pending_pixels.size() > 0 || in_valid || owed_pixels.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic push_pixel(input bit fe);
    pix_in_t p;
    p.blue_in   = $urandom_range(0, 255);
    p.green_in  = $urandom_range(0, 255);
    p.red_in    = $urandom_range(0, 255);
    p.frame_end = fe;
    pending_pixels = {pending_pixels, p};
    sent_count++;
  endtask

  task automatic push_fixed(input logic [7:0] b, g, r, input bit fe);
    pix_in_t p;
    p.blue_in   = b;
    p.green_in  = g;
    p.red_in    = r;
    p.frame_end = fe;
    pending_pixels = {pending_pixels, p};
    sent_count++;
  endtask

  task automatic set_regs(input logic [1:0] rad, input logic [6:0] pct,
                          input logic [10:0] wid);
    write_reg(REG_KERNEL_RADIUS, CFG_DATA_W'(rad));
    write_reg(REG_TRIM_PERCENT, CFG_DATA_W'(pct));
    write_reg(REG_IMAGE_WIDTH, wid);
    phase_count++;
  endtask

  initial begin
    int unsigned rad, wid, rows, total, i, f;
    logic [6:0] pct;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    radius_reg = RST_KERNEL_RADIUS;
    percent_reg = RST_TRIM_PERCENT;
    width_reg = RST_IMAGE_WIDTH;
    col_pos = 0;
    rows_done = 0;
    cur_slot = 0;
    fails = 0;
    pixels_in = 0;
    pixels_out = 0;
    windows_seen = 0;
    sent_count = 0;
    phase_count = 0;
    quiet = 0;
    hold_go = 0;
    hold_done = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero radius passes every pixel; width of zero acts as one; percent saturates
    set_regs(2'd0, 7'd127, 11'd0);
    push_fixed(8'h00, 8'hff, 8'h00, 1'b0);
    push_fixed(8'hff, 8'h00, 8'hff, 1'b0);
    push_fixed(8'haa, 8'h55, 8'h01, 1'b0);
    push_fixed(8'h80, 8'h7f, 8'hfe, 1'b1);
    drain();

    // width shrunk mid-row: the pixel at or past the new width closes its row
    set_regs(2'd0, 7'd0, 11'd8);
    for (i = 0; i < 5; i++) push_pixel(1'b0);
    drain();
    write_reg(REG_IMAGE_WIDTH, 11'd3);
    for (i = 0; i < 4; i++) push_pixel(i == 3);
    drain();

    // smallest full window, all values averaged, extremes in every channel
    set_regs(2'd1, 7'd100, 11'd3);
    for (i = 0; i < 9; i++)
      push_fixed(i[0] ? 8'hff : 8'h00, i[1] ? 8'hff : 8'h00, i == 4 ? 8'hff : 8'h00, i == 8);
    drain();

    // random phases: well-formed frames mostly, some cut short by an early frame end
    while (sent_count < 1950) begin
      rad = $urandom_range(0, 3);
      case ($urandom_range(0, 5))
        0: pct = 7'd0;
        1: pct = PCT_MAX;
        2: pct = 7'd127;
        default: pct = $urandom_range(0, 127);
      endcase
      case ($urandom_range(0, 11))
        0: wid = $urandom_range(0, 2);
        1: wid = $urandom_range(13, 2047);
        2: wid = 2047;
        default: wid = $urandom_range(3, 12);
      endcase
      // the long output hold-off must happen before the quiet tail
      if (!hold_go && sent_count > 900) begin
        rad = 3;
        wid = 9;
      end
      set_regs(rad[1:0], pct, wid[10:0]);
      if (!hold_done && rad == 3 && wid >= 7 && wid <= 12) hold_go = 1;
      if (sent_count > 1700) quiet = 1;
      for (f = 0; f < $urandom_range(1, 3); f++) begin
        rows = $urandom_range(2 * rad + 1, 2 * rad + 4);
        total = (wid == 0 ? 1 : wid) * rows;
        if (wid > 64) total = $urandom_range(1, 40);
        else if ($urandom_range(0, 7) == 0) total = $urandom_range(1, total);
        for (i = 0; i < total; i++) push_pixel(i == total - 1);
      end
      drain();
    end

    $display("covered %0d pixels in over %0d register settings, %0d filtered pixels checked",
             pixels_in, phase_count, pixels_out);
    $display("radius 0 to 3, trim 0 to 127, widths 0 to 2047, one long output hold-off");
    if (fails == 0) begin
      $display("** alpha_trimmed_mean_filter: PASSED **");
    end else begin
      $display("** alpha_trimmed_mean_filter: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** alpha_trimmed_mean_filter: FAILED **");
    $finish;
  end

endmodule

// ===== alpha_trimmed_mean_filter.f =====
hdl/atm_pkg.sv
hdl/atm_line_mem.sv
hdl/atm_lane.sv
hdl/alpha_trimmed_mean_filter.sv
dv/alpha_trimmed_mean_filter_tb.sv
